// ----- hw/rtl/cer_pkg.sv -----
package cer_pkg;

  localparam int COORD_BITS = 16;
  localparam int RAD_IN_BITS = 11;
  localparam int RAD_BITS = 10;
  localparam int IDX_BITS = 10;
  localparam int MAX_RADIUS = 1023;
  localparam int OUT_BITS = COORD_BITS + 1;
  localparam int SQ_BITS = 2 * RAD_BITS;
  localparam int PROD_BITS = 2 * SQ_BITS;
  localparam int ROOT_BITS = RAD_BITS;
  localparam int ACC_BITS = SQ_BITS + ROOT_BITS;
  localparam int TRY_BITS = PROD_BITS + 3;
  localparam int CNT_BITS = 3;

  typedef enum logic [3:0] {
    K_BEYOND,
    K_POINT,
    K_VLINE,
    K_HLINE,
    K_SPAN0,
    K_SPANS,
    K_CIRC4,
    K_CIRC8,
    K_ELL2,
    K_ELL4C,
    K_ELL4R
  } cer_kind_t;

  typedef struct packed {
    cer_kind_t                      kind;
    logic signed [COORD_BITS-1:0]   cx;
    logic signed [COORD_BITS-1:0]   cy;
    logic [RAD_BITS-1:0]            rx;
    logic [RAD_BITS-1:0]            ry;
    logic [IDX_BITS-1:0]            idx;
  } cer_item_t;

endpackage

// ----- hw/rtl/cer_ifs.sv -----
interface cer_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cer_pkg::COORD_BITS-1:0]   center_x;
  logic signed [cer_pkg::COORD_BITS-1:0]   center_y;
  logic signed [cer_pkg::RAD_IN_BITS-1:0]  radius_x;
  logic signed [cer_pkg::RAD_IN_BITS-1:0]  radius_y;
  logic                                    fill_shape;
  logic                                    sweep;
  logic [cer_pkg::IDX_BITS-1:0]            step_index;

  modport source (output valid, center_x, center_y, radius_x, radius_y, fill_shape, sweep,
                  step_index, input ready);
  modport sink (input valid, center_x, center_y, radius_x, radius_y, fill_shape, sweep,
                step_index, output ready);
endinterface

interface cer_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  prim_kind;
  logic signed [cer_pkg::OUT_BITS-1:0]   first_x;
  logic signed [cer_pkg::OUT_BITS-1:0]   first_y;
  logic signed [cer_pkg::OUT_BITS-1:0]   second_x;
  logic signed [cer_pkg::OUT_BITS-1:0]   second_y;
  logic                                  beyond;
  logic                                  last_of_run;

  modport source (output valid, prim_kind, first_x, first_y, second_x, second_y, beyond,
                  last_of_run, input ready);
  modport sink (input valid, prim_kind, first_x, first_y, second_x, second_y, beyond,
                last_of_run, output ready);
endinterface

// ----- hw/rtl/circle_ellipse_rasterizer_unit.sv -----
// channel  dir  handshake          word
// in_ch    in   valid/ready sink   center, radii, fill, sweep, index
// out_ch   out  valid/ready source one point or span, beyond, last flag
//
// input word -> front stages -> root stages -> result register -> first word
// one result word per cycle while out_ch.ready holds: 1, 2, 4 or 8 words per
// input word, so the single result port sets how often an input word is taken
// reset is synchronous; it clears the stage valid bits, result valid and counter
// stall halts the pipe only while root holds a word; nothing dropped or repeated
module circle_ellipse_rasterizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  cer_in_if.sink     in_ch,
  cer_out_if.source  out_ch
);
  import cer_pkg::*;

  logic                 en, load;
  logic                 fr_vld, rt_vld;
  cer_item_t            fr_item, rt_item;
  logic [SQ_BITS-1:0]   fr_a;
  logic [PROD_BITS-1:0] fr_b;
  logic [ROOT_BITS-1:0] rt_root;

  assign en = !rt_vld || load;

  cer_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_ch (in_ch),
    .vld   (fr_vld),
    .item  (fr_item),
    .a     (fr_a),
    .b     (fr_b)
  );

  cer_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_item  (fr_item),
    .in_a     (fr_a),
    .in_b     (fr_b),
    .out_vld  (rt_vld),
    .out_item (rt_item),
    .out_root (rt_root)
  );

  cer_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rt_vld),
    .in_item (rt_item),
    .in_root (rt_root),
    .load    (load),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  a_beyond_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.beyond |-> out_ch.last_of_run && !out_ch.prim_kind &&
      out_ch.first_x == out_ch.second_x && out_ch.first_y == out_ch.second_y)
    else $error("beyond word malformed");

  a_point_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.prim_kind |->
      out_ch.first_x == out_ch.second_x && out_ch.first_y == out_ch.second_y)
    else $error("point endpoints differ");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rt_vld && !en |=> rt_vld && $stable(rt_root))
    else $error("root stage lost on stall");
`endif

endmodule

// ----- hw/rtl/cer_front.sv -----
module cer_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  cer_in_if.sink                           in_ch,
  output logic                             vld,
  output cer_pkg::cer_item_t               item,
  output logic [cer_pkg::SQ_BITS-1:0]      a,
  output logic [cer_pkg::PROD_BITS-1:0]    b
);
  import cer_pkg::*;

  function automatic logic [RAD_BITS-1:0] sat_mag(input logic signed [RAD_IN_BITS-1:0] v);
    logic [RAD_IN_BITS-1:0] m;
    m = v[RAD_IN_BITS-1] ? RAD_IN_BITS'(-v) : RAD_IN_BITS'(v);
    return (m > RAD_IN_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : m[RAD_BITS-1:0];
  endfunction

  // stage 1: magnitudes
  logic s1_vld_r;
  cer_item_t s1_item_r;
  logic s1_fill_r, s1_rows_r;

  // stage 2: squares
  logic s2_vld_r;
  cer_item_t s2_item_r;
  logic s2_fill_r, s2_rows_r;
  logic [SQ_BITS-1:0] s2_rx2_r, s2_ry2_r, s2_i2_r;

  // stage 3: products for the root and the range tests
  logic s3_vld_r;
  cer_item_t s3_item_r;
  logic s3_fill_r, s3_rows_r, s3_c8_r;
  logic [SQ_BITS-1:0] s3_a_r;
  logic [PROD_BITS-1:0] s3_b_r, s3_rhs_r;
  logic [PROD_BITS:0] s3_lhs_r;

  // stage 4: classification
  logic s4_vld_r;
  cer_item_t s4_item_r, s4_item_nxt;
  logic [SQ_BITS-1:0] s4_a_r;
  logic [PROD_BITS-1:0] s4_b_r;

  logic s2_rowsel;
  logic [SQ_BITS-1:0] s2_a, s2_dif, s2_mb, s2_rq;
  cer_item_t s1_item_nxt;

  assign in_ch.ready = en;

  always_comb begin
    s1_item_nxt      = '0;
    s1_item_nxt.kind = K_BEYOND;
    s1_item_nxt.cx   = in_ch.center_x;
    s1_item_nxt.cy   = in_ch.center_y;
    s1_item_nxt.rx   = sat_mag(in_ch.radius_x);
    s1_item_nxt.ry   = sat_mag(in_ch.radius_y);
    s1_item_nxt.idx  = in_ch.step_index;
  end

  always_comb begin
    s2_rowsel = (s2_item_r.rx != s2_item_r.ry) && (s2_item_r.rx != '0) &&
                (s2_item_r.ry != '0) && !s2_fill_r && s2_rows_r;
    s2_a   = s2_rowsel ? s2_ry2_r : s2_rx2_r;
    s2_dif = s2_rowsel ? (s2_ry2_r - s2_i2_r) : (s2_rx2_r - s2_i2_r);
    s2_mb  = s2_rowsel ? s2_rx2_r : s2_ry2_r;
    s2_rq  = s2_rows_r ? s2_ry2_r : s2_rx2_r;
  end

  always_comb begin
    s4_item_nxt = s3_item_r;
    if (s3_item_r.rx == s3_item_r.ry) begin
      if (s3_item_r.rx == '0) begin
        s4_item_nxt.kind = (s3_item_r.idx == '0) ? K_POINT : K_BEYOND;
      end else if (s3_fill_r) begin
        if (s3_item_r.idx == '0) s4_item_nxt.kind = K_SPAN0;
        else if (s3_item_r.idx <= s3_item_r.rx) s4_item_nxt.kind = K_SPANS;
        else s4_item_nxt.kind = K_BEYOND;
      end else begin
        if (s3_item_r.idx == '0) s4_item_nxt.kind = K_CIRC4;
        else if (s3_c8_r) s4_item_nxt.kind = K_CIRC8;
        else s4_item_nxt.kind = K_BEYOND;
      end
    end else if (s3_item_r.rx == '0) begin
      s4_item_nxt.kind = (s3_item_r.idx == '0) ? K_VLINE : K_BEYOND;
    end else if (s3_item_r.ry == '0) begin
      s4_item_nxt.kind = (s3_item_r.idx == '0) ? K_HLINE : K_BEYOND;
    end else if (s3_fill_r) begin
      if (s3_item_r.idx == '0) s4_item_nxt.kind = K_SPAN0;
      else if (s3_item_r.idx <= s3_item_r.rx) s4_item_nxt.kind = K_SPANS;
      else s4_item_nxt.kind = K_BEYOND;
    end else if (!s3_rows_r) begin
      if (s3_item_r.idx == '0) s4_item_nxt.kind = K_ELL2;
      else if (s3_lhs_r <= {1'b0, s3_rhs_r}) s4_item_nxt.kind = K_ELL4C;
      else s4_item_nxt.kind = K_BEYOND;
    end else begin
      s4_item_nxt.kind = (s3_lhs_r <= {1'b0, s3_rhs_r}) ? K_ELL4R : K_BEYOND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= s1_item_nxt;
      s1_fill_r <= in_ch.fill_shape;
      s1_rows_r <= in_ch.sweep;

      s2_item_r <= s1_item_r;
      s2_fill_r <= s1_fill_r;
      s2_rows_r <= s1_rows_r;
      s2_rx2_r  <= SQ_BITS'(s1_item_r.rx * s1_item_r.rx);
      s2_ry2_r  <= SQ_BITS'(s1_item_r.ry * s1_item_r.ry);
      s2_i2_r   <= SQ_BITS'(s1_item_r.idx * s1_item_r.idx);

      s3_item_r <= s2_item_r;
      s3_fill_r <= s2_fill_r;
      s3_rows_r <= s2_rows_r;
      s3_c8_r   <= {s2_i2_r, 1'b0} <= {1'b0, s2_rx2_r};
      s3_a_r    <= s2_a;
      s3_b_r    <= PROD_BITS'(s2_mb * s2_dif);
      s3_rhs_r  <= PROD_BITS'(s2_rq * s2_rq);
      s3_lhs_r  <= (PROD_BITS + 1)'(s2_i2_r * ((SQ_BITS + 1)'(s2_rx2_r) +
                                                (SQ_BITS + 1)'(s2_ry2_r)));

      s4_item_r <= s4_item_nxt;
      s4_a_r    <= s3_a_r;
      s4_b_r    <= s3_b_r;
    end
  end

  assign vld  = s4_vld_r;
  assign item = s4_item_r;
  assign a    = s4_a_r;
  assign b    = s4_b_r;

endmodule

// ----- hw/rtl/cer_root.sv -----
module cer_root (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  cer_pkg::cer_item_t               in_item,
  input  logic [cer_pkg::SQ_BITS-1:0]      in_a,
  input  logic [cer_pkg::PROD_BITS-1:0]    in_b,
  output logic                             out_vld,
  output cer_pkg::cer_item_t               out_item,
  output logic [cer_pkg::ROOT_BITS-1:0]    out_root
);
  import cer_pkg::*;

  // one root bit per stage, msb first; p = n*n*a and q = n*a kept incrementally
  logic                 vld  [0:ROOT_BITS];
  cer_item_t            item [0:ROOT_BITS];
  logic [SQ_BITS-1:0]   a    [0:ROOT_BITS];
  logic [PROD_BITS-1:0] b    [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] n    [0:ROOT_BITS];
  logic [TRY_BITS-1:0]  p    [0:ROOT_BITS];
  logic [ACC_BITS-1:0]  q    [0:ROOT_BITS];

  assign vld[0]  = in_vld;
  assign item[0] = in_item;
  assign a[0]    = in_a;
  assign b[0]    = in_b;
  assign n[0]    = '0;
  assign p[0]    = '0;
  assign q[0]    = '0;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
    localparam int K = ROOT_BITS - 1 - g;
    logic [TRY_BITS-1:0] t;
    logic                fit;
    logic                vld_r;
    cer_item_t           item_r;
    logic [SQ_BITS-1:0]   a_r;
    logic [PROD_BITS-1:0] b_r;
    logic [ROOT_BITS-1:0] n_r;
    logic [TRY_BITS-1:0]  p_r;
    logic [ACC_BITS-1:0]  q_r;

    assign t   = p[g] + (TRY_BITS'(q[g]) << (K + 1)) + (TRY_BITS'(a[g]) << (2 * K));
    assign fit = t <= TRY_BITS'(b[g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item_r <= item[g];
        a_r    <= a[g];
        b_r    <= b[g];
        n_r    <= fit ? (n[g] | (ROOT_BITS'(1) << K)) : n[g];
        p_r    <= fit ? t : p[g];
        q_r    <= fit ? (q[g] + (ACC_BITS'(a[g]) << K)) : q[g];
      end
    end

    assign vld[g+1]  = vld_r;
    assign item[g+1] = item_r;
    assign a[g+1]    = a_r;
    assign b[g+1]    = b_r;
    assign n[g+1]    = n_r;
    assign p[g+1]    = p_r;
    assign q[g+1]    = q_r;
  end

  assign out_vld  = vld[ROOT_BITS];
  assign out_item = item[ROOT_BITS];
  assign out_root = n[ROOT_BITS];

endmodule

// ----- hw/rtl/cer_emit.sv -----
module cer_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  cer_pkg::cer_item_t               in_item,
  input  logic [cer_pkg::ROOT_BITS-1:0]    in_root,
  output logic                             load,
  cer_out_if.source                        out_ch
);
  import cer_pkg::*;

  function automatic logic [OUT_BITS-1:0] offs(input logic signed [COORD_BITS-1:0] c,
                                               input logic [RAD_BITS-1:0] o,
                                               input logic neg);
    logic [OUT_BITS-1:0] c17;
    logic [OUT_BITS-1:0] o17;
    c17 = OUT_BITS'(c);
    o17 = OUT_BITS'(o);
    return neg ? (c17 - o17) : (c17 + o17);
  endfunction

  cer_item_t            item_r;
  logic [ROOT_BITS-1:0] root_r;
  logic                 busy_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [CNT_BITS-1:0]  last_cnt;
  logic                 last, take;
  logic [OUT_BITS-1:0]  cx, cy, x1, y1, x2, y2;
  logic [RAD_BITS-1:0]  ax;
  logic                 kind_line;

  always_comb begin
    case (item_r.kind)
      K_SPANS, K_ELL2: last_cnt = CNT_BITS'(1);
      K_CIRC4, K_ELL4C, K_ELL4R: last_cnt = CNT_BITS'(3);
      K_CIRC8: last_cnt = CNT_BITS'(7);
      default: last_cnt = '0;
    endcase
  end

  assign last = cnt_r == last_cnt;
  assign take = out_ch.valid && out_ch.ready;
  assign load = in_vld && (!busy_r || (take && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (take) begin
      if (last) busy_r <= 1'b0;
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
      root_r <= in_root;
    end
  end

  always_comb begin
    cx        = OUT_BITS'(item_r.cx);
    cy        = OUT_BITS'(item_r.cy);
    ax        = (item_r.kind == K_CIRC4) ? item_r.rx : item_r.ry;
    kind_line = 1'b0;
    x1        = cx;
    y1        = cy;
    x2        = cx;
    y2        = cy;
    case (item_r.kind)
      K_VLINE: begin
        kind_line = 1'b1;
        y1 = offs(item_r.cy, item_r.ry, 1'b1);
        y2 = offs(item_r.cy, item_r.ry, 1'b0);
      end
      K_HLINE: begin
        kind_line = 1'b1;
        x1 = offs(item_r.cx, item_r.rx, 1'b1);
        x2 = offs(item_r.cx, item_r.rx, 1'b0);
      end
      K_SPAN0: begin
        kind_line = 1'b1;
        y1 = offs(item_r.cy, item_r.ry, 1'b0);
        y2 = offs(item_r.cy, item_r.ry, 1'b1);
      end
      K_SPANS: begin
        kind_line = 1'b1;
        x1 = offs(item_r.cx, item_r.idx, cnt_r[0]);
        x2 = x1;
        y1 = offs(item_r.cy, root_r, 1'b0);
        y2 = offs(item_r.cy, root_r, 1'b1);
      end
      K_CIRC4, K_ELL2: begin
        if (!cnt_r[1]) y1 = offs(item_r.cy, ax, cnt_r[0]);
        else x1 = offs(item_r.cx, ax, cnt_r[0]);
        x2 = x1;
        y2 = y1;
      end
      K_CIRC8, K_ELL4C: begin
        if (!cnt_r[2]) begin
          x1 = offs(item_r.cx, item_r.idx, cnt_r[1]);
          y1 = offs(item_r.cy, root_r, cnt_r[0]);
        end else begin
          x1 = offs(item_r.cx, root_r, cnt_r[1]);
          y1 = offs(item_r.cy, item_r.idx, cnt_r[0]);
        end
        x2 = x1;
        y2 = y1;
      end
      K_ELL4R: begin
        x1 = offs(item_r.cx, root_r, cnt_r[1]);
        y1 = offs(item_r.cy, item_r.idx, cnt_r[0]);
        x2 = x1;
        y2 = y1;
      end
      default: begin
        kind_line = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_ch.valid       = busy_r;
    out_ch.prim_kind   = kind_line;
    out_ch.first_x     = x1;
    out_ch.first_y     = y1;
    out_ch.second_x    = x2;
    out_ch.second_y    = y2;
    out_ch.beyond      = item_r.kind == K_BEYOND;
    out_ch.last_of_run = last;
  end

endmodule
